// ===== rtl/cect_pkg.sv =====
// ----------------------------------------------------------------------------
// cect_pkg
// Shared types and codes for the coalescing event counter table.
// ----------------------------------------------------------------------------
`default_nettype none

package cect_pkg;

  // Operation carried in in_tuser
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Result status carried in out_tuser
  localparam logic [2:0] ST_COALESCED = 3'd0;
  localparam logic [2:0] ST_NEW       = 3'd1;
  localparam logic [2:0] ST_DROPPED   = 3'd2;
  localparam logic [2:0] ST_READ_OK   = 3'd3;
  localparam logic [2:0] ST_READ_OOR  = 3'd4;

  localparam int IN_DATA_W  = 240;
  localparam int OUT_DATA_W = 312;

  // Coalescing key: event kind plus three arguments
  typedef struct packed {
    logic [63:0] arg2;
    logic [63:0] arg1;
    logic [63:0] arg0;
    logic [9:0]  syscall_number;
  } key_t;

  // One queued request between the front and the back
  typedef struct packed {
    logic        op;
    key_t        key;
    logic [21:0] caller_id;
    logic [8:0]  read_index;
  } req_t;

  // One result word
  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  entry_index;
    logic [31:0] entry_count;
    logic [9:0]  occupied;
    logic [31:0] dropped_total;
    logic [9:0]  entry_syscall;
    logic [63:0] entry_arg0;
    logic [63:0] entry_arg1;
    logic [63:0] entry_arg2;
    logic [21:0] entry_caller;
  } res_t;

  // Queue head as seen by the back
  typedef struct packed {
    logic valid;
    req_t req;
  } qhead_t;

endpackage

`default_nettype wire

// ===== rtl/cect_front.sv =====
// ----------------------------------------------------------------------------
// cect_front
// Accepts input words, splits them into requests and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module cect_front (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [cect_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire                             in_tuser,
  output cect_pkg::qhead_t                head,
  input  wire                             pop
);

  cect_pkg::req_t fifo_q [2];
  cect_pkg::req_t in_req;
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;

  // Unpack the input word
  always_comb begin
    in_req                    = '0;
    in_req.op                 = in_tuser;
    in_req.key.syscall_number = in_tdata[9:0];
    in_req.key.arg0           = in_tdata[73:10];
    in_req.key.arg1           = in_tdata[137:74];
    in_req.key.arg2           = in_tdata[201:138];
    in_req.caller_id          = in_tdata[223:202];
    in_req.read_index         = in_tdata[232:224];
  end

  assign in_tready  = (cnt_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign head.valid = (cnt_r != 2'd0);
  assign head.req   = fifo_q[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_q[wr_ptr_r] <= in_req;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cect_back.sv =====
// ----------------------------------------------------------------------------
// cect_back
// Table engine: scans stored keys, coalesces, appends, drops and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module cect_back #(
  parameter int ENTRIES = 512
) (
  input  wire                clk,
  input  wire                rst_n,
  input  cect_pkg::qhead_t   head,
  output logic               pop,
  output cect_pkg::res_t     res,
  output logic               res_valid,
  input  wire                res_ready
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RDWAIT = 2'd2;

  // Table memories, one write and one read port each
  cect_pkg::key_t key_mem    [ENTRIES];
  logic [21:0]    caller_mem [ENTRIES];
  logic [31:0]    cnt_mem    [ENTRIES];

  cect_pkg::key_t key_rd_r;
  logic [21:0]    caller_rd_r;
  logic [31:0]    cnt_rd_r;

  logic [1:0]     state_r, state_nxt;
  cect_pkg::req_t cur_r, cur_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [31:0]    drop_r, drop_nxt;
  cect_pkg::res_t res_r, res_nxt;
  logic           res_valid_r, res_valid_nxt;

  cect_pkg::req_t   act_req;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             key_we;
  logic             cnt_we;
  logic [31:0]      cnt_wdata;
  logic [31:0]      cnt_inc;
  logic             do_miss;
  logic [CNT_W-1:0] fill_inc;

  assign res       = res_r;
  assign res_valid = res_valid_r;

  assign cnt_inc  = (cnt_rd_r == 32'hFFFF_FFFF) ? cnt_rd_r : cnt_rd_r + 32'd1;
  assign fill_inc = fill_r + CNT_W'(1);
  assign act_req  = (state_r == S_IDLE) ? head.req : cur_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cmp_idx_nxt   = cmp_idx_r;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;
    pop           = 1'b0;
    rd_addr       = cmp_idx_r + IDX_W'(1);
    wr_addr       = cmp_idx_r;
    key_we        = 1'b0;
    cnt_we        = 1'b0;
    cnt_wdata     = cnt_inc;
    do_miss       = 1'b0;

    case (state_r)
      S_IDLE: begin
        // Take a request only when the result register is free
        if (head.valid && !res_valid_r) begin
          pop     = 1'b1;
          cur_nxt = head.req;
          if (head.req.op == cect_pkg::OP_READ) begin
            rd_addr = IDX_W'(head.req.read_index);
            if ((32'(head.req.read_index) < 32'(fill_r)) &&
                (32'(head.req.read_index) < ENTRIES)) begin
              state_nxt = S_RDWAIT;
            end else begin
              res_nxt               = '0;
              res_nxt.status        = cect_pkg::ST_READ_OOR;
              res_nxt.entry_index   = head.req.read_index;
              res_nxt.occupied      = 10'(fill_r);
              res_nxt.dropped_total = drop_r;
              res_valid_nxt         = 1'b1;
            end
          end else if (fill_r == '0) begin
            do_miss = 1'b1;
          end else begin
            rd_addr     = '0;
            cmp_idx_nxt = '0;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Read data belongs to cmp_idx_r
        if (key_rd_r == cur_r.key) begin
          cnt_we                = 1'b1;
          res_nxt               = '0;
          res_nxt.status        = cect_pkg::ST_COALESCED;
          res_nxt.entry_index   = 9'(cmp_idx_r);
          res_nxt.entry_count   = cnt_inc;
          res_nxt.occupied      = 10'(fill_r);
          res_nxt.dropped_total = drop_r;
          res_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end else if ((32'(cmp_idx_r) + 32'd1) == 32'(fill_r)) begin
          do_miss   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmp_idx_nxt = cmp_idx_r + IDX_W'(1);
        end
      end
      S_RDWAIT: begin
        res_nxt               = '0;
        res_nxt.status        = cect_pkg::ST_READ_OK;
        res_nxt.entry_index   = cur_r.read_index;
        res_nxt.entry_count   = cnt_rd_r;
        res_nxt.occupied      = 10'(fill_r);
        res_nxt.dropped_total = drop_r;
        res_nxt.entry_syscall = key_rd_r.syscall_number;
        res_nxt.entry_arg0    = key_rd_r.arg0;
        res_nxt.entry_arg1    = key_rd_r.arg1;
        res_nxt.entry_arg2    = key_rd_r.arg2;
        res_nxt.entry_caller  = caller_rd_r;
        res_valid_nxt         = 1'b1;
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // No stored key matched: append or drop
    if (do_miss) begin
      res_nxt       = '0;
      res_valid_nxt = 1'b1;
      if (32'(fill_r) >= ENTRIES) begin
        drop_nxt              = (drop_r == 32'hFFFF_FFFF) ? drop_r : drop_r + 32'd1;
        res_nxt.status        = cect_pkg::ST_DROPPED;
        res_nxt.occupied      = 10'(fill_r);
        res_nxt.dropped_total = drop_nxt;
      end else begin
        key_we                = 1'b1;
        cnt_we                = 1'b1;
        cnt_wdata             = 32'd1;
        wr_addr               = IDX_W'(fill_r);
        fill_nxt              = fill_inc;
        res_nxt.status        = cect_pkg::ST_NEW;
        res_nxt.entry_index   = 9'(fill_r);
        res_nxt.entry_count   = 32'd1;
        res_nxt.occupied      = 10'(fill_inc);
        res_nxt.dropped_total = drop_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      drop_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    res_r     <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr]    <= act_req.key;
      caller_mem[wr_addr] <= act_req.caller_id;
    end
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    key_rd_r    <= key_mem[rd_addr];
    caller_rd_r <= caller_mem[rd_addr];
    cnt_rd_r    <= cnt_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/coalescing_event_counter_table_unit.sv =====
// Order: a read in range passes from accept through S_RDWAIT to out_tvalid; a read
//   past occupancy is answered from the accept state; a record scans one stored key
//   per cycle up to occupied, through the single read port of the key memory. The
//   back takes a new request only once the last result has been taken.
// Reset: rst_n clears the queue, fill count, drop counter and output valid;
//   the table memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// coalescing_event_counter_table_unit
// Event table that merges repeated events into per-key counts.
// ----------------------------------------------------------------------------
`default_nettype none

module coalescing_event_counter_table_unit #(
  parameter int ENTRIES = 512
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // Input channel
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // tdata: syscall_number[9:0], arg0[73:10], arg1[137:74], arg2[201:138],
  //        caller_id[223:202], read_index[232:224], zero pad[239:233]
  input  wire  [cect_pkg::IN_DATA_W-1:0]   in_tdata,
  // tuser: op
  input  wire                              in_tuser,
  // Result channel
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // tdata: entry_index[8:0], entry_count[40:9], occupied[50:41],
  //        dropped_total[82:51], entry_syscall[92:83], entry_arg0[156:93],
  //        entry_arg1[220:157], entry_arg2[284:221], entry_caller[306:285],
  //        zero pad[311:307]
  output logic [cect_pkg::OUT_DATA_W-1:0]  out_tdata,
  // tuser: status
  output logic [2:0]                       out_tuser
);

  cect_pkg::qhead_t head;
  logic             pop;
  cect_pkg::res_t   res;

  // Front: accept words and buffer them in a two-deep queue so the input
  // side keeps moving while the back scans or holds a result.
  cect_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head      (head),
    .pop       (pop)
  );

  // Back: walk the table one entry per cycle, then update count, append,
  // drop or return a stored entry. The result sits in a register until taken.
  cect_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .res       (res),
    .res_valid (out_tvalid),
    .res_ready (out_tready)
  );

  // Pack the result word
  assign out_tuser = res.status;
  assign out_tdata = {5'd0,
                      res.entry_caller,
                      res.entry_arg2,
                      res.entry_arg1,
                      res.entry_arg0,
                      res.entry_syscall,
                      res.dropped_total,
                      res.occupied,
                      res.entry_count,
                      res.entry_index};

endmodule

`default_nettype wire
